[rtl/brc_pkg.sv]
package brc_pkg;

    localparam int DIM_W          = 13;
    localparam int POS_W          = 15;
    localparam int OUT_W          = 16;
    // Internal coordinate width: holds every corner and size that the two
    // clips can produce, including the shifted corner of the other image.
    localparam int CALC_W         = 18;
    localparam int COORD_BITS_DEF = 16;

    typedef logic [DIM_W-1:0]         dim_t;
    typedef logic signed [CALC_W-1:0] calc_t;

    // Result of clipping one axis against [0, lim).
    typedef struct packed {
        logic  ok;
        calc_t len;
        calc_t pos;
        calc_t other;
    } axis_t;

    // Payload carried down the pipeline.
    typedef struct packed {
        logic  ok;
        logic  dest_only;
        dim_t  sw;
        dim_t  sh;
        dim_t  dw;
        dim_t  dh;
        calc_t w;
        calc_t h;
        calc_t dx;
        calc_t dy;
        calc_t sx;
        calc_t sy;
    } stage_t;

    function automatic calc_t dim_to_calc(dim_t d);
        return signed'({{(CALC_W-DIM_W){1'b0}}, d});
    endfunction

    // Clip one axis. A left or top trim moves the other image's corner by
    // the same amount; a far-edge overrun shortens the length.
    function automatic axis_t clip_axis(dim_t lim, calc_t len, calc_t pos, calc_t other);
        axis_t r;
        calc_t lim_s;
        calc_t end_pos;
        lim_s   = dim_to_calc(lim);
        r.ok    = 1'b1;
        r.len   = len;
        r.pos   = pos;
        r.other = other;
        if (pos < 0 && -pos >= len)
        begin
            r.ok = 1'b0;
        end
        if (pos > 0 && pos >= lim_s)
        begin
            r.ok = 1'b0;
        end
        if (pos < 0)
        begin
            r.len   = len + pos;
            r.other = other - pos;
            r.pos   = '0;
        end
        end_pos = r.pos + r.len;
        if (end_pos > lim_s)
        begin
            r.len = lim_s - r.pos;
        end
        return r;
    endfunction

endpackage

[rtl/brc_intf.sv]
interface brc_req_if;
    logic                    valid;
    logic                    ready;
    logic                    dest_only;
    logic [12:0]             src_width;
    logic [12:0]             src_height;
    logic [12:0]             dst_width;
    logic [12:0]             dst_height;
    logic [12:0]             rect_width;
    logic [12:0]             rect_height;
    logic signed [14:0]      dst_x;
    logic signed [14:0]      dst_top;
    logic signed [14:0]      src_x;
    logic signed [14:0]      src_top;

    modport source (
        output valid, dest_only, src_width, src_height, dst_width, dst_height,
               rect_width, rect_height, dst_x, dst_top, src_x, src_top,
        input  ready
    );
    modport sink (
        input  valid, dest_only, src_width, src_height, dst_width, dst_height,
               rect_width, rect_height, dst_x, dst_top, src_x, src_top,
        output ready
    );
endinterface

interface brc_res_if;
    logic                    valid;
    logic                    ready;
    logic                    visible;
    logic [12:0]             out_width;
    logic [12:0]             out_height;
    logic signed [15:0]      out_dst_x;
    logic signed [15:0]      out_dst_top;
    logic signed [15:0]      out_src_x;
    logic signed [15:0]      out_src_top;

    modport source (
        output valid, visible, out_width, out_height, out_dst_x, out_dst_top,
               out_src_x, out_src_top,
        input  ready
    );
    modport sink (
        input  valid, visible, out_width, out_height, out_dst_x, out_dst_top,
               out_src_x, out_src_top,
        output ready
    );
endinterface

[rtl/brc_clip_stage.sv]
module brc_clip_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           src_side,
    input  logic           in_valid,
    output logic           in_ready,
    input  brc_pkg::stage_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output brc_pkg::stage_t out_data
);
    import brc_pkg::*;

    logic   valid_reg;
    stage_t data_reg;
    stage_t data_next;
    axis_t  ax;
    axis_t  ay;
    logic   clip_en;

    // One stage clips both axes in parallel, either against the source
    // image (skipped for fills) or against the destination image.
    always_comb
    begin
        data_next = in_data;
        if (src_side)
        begin
            ax      = clip_axis(in_data.sw, in_data.w, in_data.sx, in_data.dx);
            ay      = clip_axis(in_data.sh, in_data.h, in_data.sy, in_data.dy);
            clip_en = in_data.ok && !in_data.dest_only;
            if (clip_en)
            begin
                data_next.ok = ax.ok && ay.ok;
                data_next.w  = ax.len;
                data_next.sx = ax.pos;
                data_next.dx = ax.other;
                data_next.h  = ay.len;
                data_next.sy = ay.pos;
                data_next.dy = ay.other;
            end
        end
        else
        begin
            ax      = clip_axis(in_data.dw, in_data.w, in_data.dx, in_data.sx);
            ay      = clip_axis(in_data.dh, in_data.h, in_data.dy, in_data.sy);
            clip_en = in_data.ok;
            if (clip_en)
            begin
                data_next.ok = ax.ok && ay.ok;
                data_next.w  = ax.len;
                data_next.dx = ax.pos;
                data_next.sx = ax.other;
                data_next.h  = ay.len;
                data_next.dy = ay.pos;
                data_next.sy = ay.other;
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

[rtl/blit_rect_clipper.sv]
// Channel  Modport  Beat carries
// -------  -------  ---------------------------------------------------------
// req      sink     one blit request: image sizes, rectangle size, corners
// res      source   one clipped rectangle: visible, size, both corners
//
// Three register stages: source clip, destination clip, output format.
// A beat can be taken every cycle unless res stalls. Each stage holds its
// own valid bit and only refills when it is empty or its successor takes
// its beat, so a stall on res backs up stage by stage and no beat is lost
// or repeated. Reset clears the valid bits only.
module blit_rect_clipper #(
    parameter int COORD_BITS = brc_pkg::COORD_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    brc_req_if.sink       req,
    brc_res_if.source     res
);
    import brc_pkg::*;

    // Output corners are taken modulo 2^COORD_BITS before they reach the
    // 16-bit result fields.
    localparam logic [OUT_W-1:0] CoordMask =
        (COORD_BITS >= OUT_W) ? {OUT_W{1'b1}} : OUT_W'((64'd1 << COORD_BITS) - 64'd1);

    stage_t in_stage;
    stage_t s1_data;
    stage_t s2_data;
    logic   s1_valid;
    logic   s1_ready;
    logic   s2_valid;
    logic   s2_ready;

    logic                     res_valid_reg;
    logic                     visible_reg;
    logic [DIM_W-1:0]         width_reg;
    logic [DIM_W-1:0]         height_reg;
    logic signed [OUT_W-1:0]  dst_x_reg;
    logic signed [OUT_W-1:0]  dst_top_reg;
    logic signed [OUT_W-1:0]  src_x_reg;
    logic signed [OUT_W-1:0]  src_top_reg;

    logic                     visible_next;
    logic [DIM_W-1:0]         width_next;
    logic [DIM_W-1:0]         height_next;
    logic signed [OUT_W-1:0]  dst_x_next;
    logic signed [OUT_W-1:0]  dst_top_next;
    logic signed [OUT_W-1:0]  src_x_next;
    logic signed [OUT_W-1:0]  src_top_next;

    // Widen the request into the internal coordinate format. An empty
    // rectangle is marked as rejected right away.
    always_comb
    begin
        in_stage.ok        = (req.rect_width != '0) && (req.rect_height != '0);
        in_stage.dest_only = req.dest_only;
        in_stage.sw        = req.src_width;
        in_stage.sh        = req.src_height;
        in_stage.dw        = req.dst_width;
        in_stage.dh        = req.dst_height;
        in_stage.w         = dim_to_calc(req.rect_width);
        in_stage.h         = dim_to_calc(req.rect_height);
        in_stage.dx        = CALC_W'(req.dst_x);
        in_stage.dy        = CALC_W'(req.dst_top);
        in_stage.sx        = CALC_W'(req.src_x);
        in_stage.sy        = CALC_W'(req.src_top);
    end

    // Stage one: clip against the source image unless this is a fill.
    brc_clip_stage u_src_clip (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_side  (1'b1),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_data   (in_stage),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    // Stage two: clip against the destination image.
    brc_clip_stage u_dst_clip (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_side  (1'b0),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    // Stage three: final emptiness check, zeroing of rejected rectangles and
    // reduction of the corners to the output coordinate range.
    always_comb
    begin
        visible_next = s2_data.ok && (s2_data.w > 0) && (s2_data.h > 0);
        if (visible_next)
        begin
            width_next   = s2_data.w[DIM_W-1:0];
            height_next  = s2_data.h[DIM_W-1:0];
            dst_x_next   = signed'(s2_data.dx[OUT_W-1:0] & CoordMask);
            dst_top_next = signed'(s2_data.dy[OUT_W-1:0] & CoordMask);
            src_x_next   = signed'(s2_data.sx[OUT_W-1:0] & CoordMask);
            src_top_next = signed'(s2_data.sy[OUT_W-1:0] & CoordMask);
        end
        else
        begin
            width_next   = '0;
            height_next  = '0;
            dst_x_next   = '0;
            dst_top_next = '0;
            src_x_next   = '0;
            src_top_next = '0;
        end
    end

    // The output register refills whenever it is empty or being drained,
    // so a result waiting on res never blocks the stages behind it longer
    // than the consumer holds ready low.
    assign s2_ready = !res_valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            res_valid_reg <= s2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s2_valid)
        begin
            visible_reg <= visible_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            dst_x_reg   <= dst_x_next;
            dst_top_reg <= dst_top_next;
            src_x_reg   <= src_x_next;
            src_top_reg <= src_top_next;
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.visible     = visible_reg;
    assign res.out_width   = width_reg;
    assign res.out_height  = height_reg;
    assign res.out_dst_x   = dst_x_reg;
    assign res.out_dst_top = dst_top_reg;
    assign res.out_src_x   = src_x_reg;
    assign res.out_src_top = src_top_reg;

endmodule

[rtl/brc_checker.sv]
module brc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               res_valid,
    input logic               res_ready,
    input logic               visible,
    input logic [12:0]        out_width,
    input logic [12:0]        out_height,
    input logic signed [15:0] out_dst_x,
    input logic signed [15:0] out_dst_top,
    input logic signed [15:0] out_src_x,
    input logic signed [15:0] out_src_top
);

    // A rejected rectangle carries nothing but zeros.
    a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !visible |->
            out_width == 13'd0 && out_height == 13'd0 &&
            out_dst_x == 16'sd0 && out_dst_top == 16'sd0 &&
            out_src_x == 16'sd0 && out_src_top == 16'sd0)
        else $error("rejected result has nonzero fields");

    // A visible rectangle is never empty.
    a_visible_size: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && visible |-> out_width != 13'd0 && out_height != 13'd0)
        else $error("visible result with empty size");

    // A visible destination corner is never negative: the destination clip puts it inside the image.
    a_dst_inside: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && visible |-> !out_dst_x[15] && !out_dst_top[15])
        else $error("visible destination corner is negative");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=>
            res_valid && $stable(visible) && $stable(out_width) &&
            $stable(out_height) && $stable(out_dst_x) && $stable(out_dst_top) &&
            $stable(out_src_x) && $stable(out_src_top))
        else $error("stalled result changed");

endmodule

bind blit_rect_clipper brc_checker u_brc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .visible      (res.visible),
    .out_width    (res.out_width),
    .out_height   (res.out_height),
    .out_dst_x    (res.out_dst_x),
    .out_dst_top  (res.out_dst_top),
    .out_src_x    (res.out_src_x),
    .out_src_top  (res.out_src_top)
);

[dv/blit_rect_clipper_test.sv]
`timescale 1ns / 100ps

module blit_rect_clipper_test;

    import brc_pkg::*;

    localparam int CLK_PERIOD       = 10;
    localparam int RESET_CYCLES     = 8;
    localparam int COORD_BITS       = COORD_BITS_DEF;
    // The block is a three-stage pipeline; this is its request-to-result delay.
    localparam int PIPE_LATENCY     = 3;
    localparam int RANDOM_PER_PHASE = 560;
    // Long enough that the three stages, the last being the output register, fill
    // up and the request side has to stall while the sender keeps a beat on offer.
    localparam int SINK_HOLD_CYCLES = 80;
    localparam int WATCHDOG_CYCLES  = 200000;

    // Traffic profiles. The first pair sets sender and receiver idling
    // against each other; the last one runs both sides flat out.
    typedef enum int {
        PROFILE_SLOW_SINK,
        PROFILE_SLOW_SOURCE,
        PROFILE_FREE
    } traffic_t;

    // One blit request exactly as it goes onto the request channel.
    typedef struct packed {
        logic                    dest_only;
        dim_t                    src_width;
        dim_t                    src_height;
        dim_t                    dst_width;
        dim_t                    dst_height;
        dim_t                    rect_width;
        dim_t                    rect_height;
        logic signed [POS_W-1:0] dst_x;
        logic signed [POS_W-1:0] dst_top;
        logic signed [POS_W-1:0] src_x;
        logic signed [POS_W-1:0] src_top;
    } blit_req_t;

    // One clipped rectangle as it comes off the result channel.
    typedef struct packed {
        logic                    visible;
        dim_t                    out_width;
        dim_t                    out_height;
        logic signed [OUT_W-1:0] out_dst_x;
        logic signed [OUT_W-1:0] out_dst_top;
        logic signed [OUT_W-1:0] out_src_x;
        logic signed [OUT_W-1:0] out_src_top;
    } clip_rect_t;

    // A request waiting to be sent, tagged with how the traffic around it
    // should look. drain_first makes the sender wait until every outstanding
    // result has come back; hold_sink starts a long receiver stall.
    typedef struct {
        blit_req_t beat;
        traffic_t  profile;
        bit        drain_first;
        bit        hold_sink;
    } queued_req_t;

    logic clk = 1'b0;
    logic rst_n;

    brc_req_if req_ch ();
    brc_res_if res_ch ();

    blit_rect_clipper i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    queued_req_t request_q[$];
    clip_rect_t  clipped_q[$];

    // Settings that the next queued request picks up when it is built.
    traffic_t fill_profile = PROFILE_SLOW_SINK;
    bit       fill_drain   = 1'b0;
    bit       fill_hold    = 1'b0;

    traffic_t traffic;
    logic     hold_kick;
    int       hold_left;
    int       failures = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Clip one axis against [0, lim). A negative corner is pulled to zero,
    // and the corner in the other image moves by the same amount; a span
    // that runs past the far edge is cut short. Returns 0 when nothing of
    // the span lies inside.
    function automatic bit trim_axis(input longint lim, inout longint span,
                                     inout longint corner, inout longint twin);
        if (corner < 0 && -corner >= span)
        begin
            return 1'b0;
        end
        if (corner > 0 && corner >= lim)
        begin
            return 1'b0;
        end
        if (corner < 0)
        begin
            span   = span + corner;
            twin   = twin - corner;
            corner = 0;
        end
        if (corner + span > lim)
        begin
            span = lim - corner;
        end
        return 1'b1;
    endfunction

    // Expected result for one request: clip against the source image unless
    // the request is a fill, then against the destination image.
    function automatic clip_rect_t clip_blit(input blit_req_t r);
        longint     w;
        longint     h;
        longint     dx;
        longint     dy;
        longint     sx;
        longint     sy;
        longint     mask;
        bit         ok;
        clip_rect_t c;
        w    = longint'(r.rect_width);
        h    = longint'(r.rect_height);
        dx   = longint'(r.dst_x);
        dy   = longint'(r.dst_top);
        sx   = longint'(r.src_x);
        sy   = longint'(r.src_top);
        mask = (longint'(1) << COORD_BITS) - 1;
        ok   = (w != 0) && (h != 0);
        if (ok && !r.dest_only)
        begin
            ok = trim_axis(longint'(r.src_width), w, sx, dx);
            if (ok)
            begin
                ok = trim_axis(longint'(r.src_height), h, sy, dy);
            end
        end
        if (ok)
        begin
            ok = trim_axis(longint'(r.dst_width), w, dx, sx);
        end
        if (ok)
        begin
            ok = trim_axis(longint'(r.dst_height), h, dy, sy);
        end
        if (ok && (w <= 0 || h <= 0))
        begin
            ok = 1'b0;
        end
        c = '0;
        if (ok)
        begin
            c.visible     = 1'b1;
            c.out_width   = w[DIM_W-1:0];
            c.out_height  = h[DIM_W-1:0];
            c.out_dst_x   = OUT_W'(dx & mask);
            c.out_dst_top = OUT_W'(dy & mask);
            c.out_src_x   = OUT_W'(sx & mask);
            c.out_src_top = OUT_W'(sy & mask);
        end
        return c;
    endfunction

    // Build one request and queue it, consuming the one-shot traffic flags.
    task automatic queue_blit(input bit only, input int sw, input int sh,
                              input int dw, input int dh, input int rw,
                              input int rh, input int dl, input int dt,
                              input int sl, input int st);
        queued_req_t q;
        q.beat.dest_only   = only;
        q.beat.src_width   = sw[DIM_W-1:0];
        q.beat.src_height  = sh[DIM_W-1:0];
        q.beat.dst_width   = dw[DIM_W-1:0];
        q.beat.dst_height  = dh[DIM_W-1:0];
        q.beat.rect_width  = rw[DIM_W-1:0];
        q.beat.rect_height = rh[DIM_W-1:0];
        q.beat.dst_x       = dl[POS_W-1:0];
        q.beat.dst_top     = dt[POS_W-1:0];
        q.beat.src_x       = sl[POS_W-1:0];
        q.beat.src_top     = st[POS_W-1:0];
        q.profile          = fill_profile;
        q.drain_first      = fill_drain;
        q.hold_sink        = fill_hold;
        fill_drain         = 1'b0;
        fill_hold          = 1'b0;
        request_q.push_back(q);
    endtask

    // Image and rectangle sizes lean toward small values so that many
    // rectangles land partly inside, with the extremes mixed in.
    function automatic int rand_dim();
        case ($urandom_range(0, 9))
            0:       return 1;
            1:       return (1 << DIM_W) - 1;
            2, 3, 4: return int'($urandom_range(1, 64));
            default: return int'($urandom_range(1, (1 << DIM_W) - 1));
        endcase
    endfunction

    // A corner for a span of the given length in an image of the given
    // extent. Most corners fall where the span at least touches the image;
    // the rest are the edge cases and full-range noise.
    function automatic int rand_corner(input int span, input int extent);
        case ($urandom_range(0, 11))
            0:       return int'($urandom_range(0, (1 << POS_W) - 1)) - (1 << (POS_W - 1));
            1:       return -(1 << (POS_W - 1));
            2:       return (1 << (POS_W - 1)) - 1;
            3:       return extent;
            4:       return -span;
            default: return int'($urandom_range(0, span + extent)) - span;
        endcase
    endfunction

    task automatic compare_field(input string name, input logic signed [31:0] want,
                                 input logic signed [31:0] seen);
        if (want !== seen)
        begin
            failures++;
            $error("%s: expected %0d, got %0d", name, want, seen);
        end
    endtask

    // Request driver. A beat stays on the channel until it is taken; only
    // then, or while the channel is empty, is the next one considered. The
    // expected result is worked out at the edge where the beat is accepted.
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        queued_req_t nxt;
        blit_req_t   on_bus;
        bit          offer;
        int          idle_pct;
        if (!rst_n)
        begin
            req_ch.valid       <= 1'b0;
            req_ch.dest_only   <= 1'b0;
            req_ch.src_width   <= '0;
            req_ch.src_height  <= '0;
            req_ch.dst_width   <= '0;
            req_ch.dst_height  <= '0;
            req_ch.rect_width  <= '0;
            req_ch.rect_height <= '0;
            req_ch.dst_x       <= '0;
            req_ch.dst_top     <= '0;
            req_ch.src_x       <= '0;
            req_ch.src_top     <= '0;
            hold_kick          <= 1'b0;
            traffic            <= PROFILE_SLOW_SINK;
        end
        else
        begin
            offer = 1'b0;
            if (req_ch.valid && req_ch.ready)
            begin
                clipped_q.push_back(clip_blit(on_bus));
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (request_q.size() != 0)
                begin
                    nxt = request_q[0];
                    case (nxt.profile)
                        PROFILE_SLOW_SINK:   idle_pct = 14;
                        PROFILE_SLOW_SOURCE: idle_pct = 66;
                        default:             idle_pct = 0;
                    endcase
                    // A drain point holds the sender until the pipeline is
                    // empty; otherwise the sender idles at its profile's rate.
                    if (nxt.drain_first)
                    begin
                        offer = (clipped_q.size() == 0);
                    end
                    else
                    begin
                        offer = ($urandom_range(0, 99) >= idle_pct);
                    end
                end
                if (offer)
                begin
                    void'(request_q.pop_front());
                    on_bus                = nxt.beat;
                    traffic              <= nxt.profile;
                    req_ch.dest_only     <= nxt.beat.dest_only;
                    req_ch.src_width     <= nxt.beat.src_width;
                    req_ch.src_height    <= nxt.beat.src_height;
                    req_ch.dst_width     <= nxt.beat.dst_width;
                    req_ch.dst_height    <= nxt.beat.dst_height;
                    req_ch.rect_width    <= nxt.beat.rect_width;
                    req_ch.rect_height   <= nxt.beat.rect_height;
                    req_ch.dst_x         <= nxt.beat.dst_x;
                    req_ch.dst_top       <= nxt.beat.dst_top;
                    req_ch.src_x         <= nxt.beat.src_x;
                    req_ch.src_top       <= nxt.beat.src_top;
                end
                req_ch.valid <= offer;
            end
            hold_kick <= offer && nxt.hold_sink;
        end
    end

    // Counts down a long receiver stall once the driver kicks it off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
        end
        else if (hold_kick)
        begin
            hold_left <= SINK_HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor. Every accepted result beat is checked against the
    // oldest outstanding expectation, field by field.
    always @(posedge clk or negedge rst_n)
    begin : watch_results
        clip_rect_t got;
        clip_rect_t want;
        int         idle_pct;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                got.visible     = res_ch.visible;
                got.out_width   = res_ch.out_width;
                got.out_height  = res_ch.out_height;
                got.out_dst_x   = res_ch.out_dst_x;
                got.out_dst_top = res_ch.out_dst_top;
                got.out_src_x   = res_ch.out_src_x;
                got.out_src_top = res_ch.out_src_top;
                if (clipped_q.size() == 0)
                begin
                    failures++;
                    $error("result beat arrived with no request outstanding");
                end
                else
                begin
                    want = clipped_q.pop_front();
                    compare_field("visible", 32'(want.visible), 32'(got.visible));
                    compare_field("out_width", 32'(want.out_width), 32'(got.out_width));
                    compare_field("out_height", 32'(want.out_height), 32'(got.out_height));
                    compare_field("out_dst_x", 32'(want.out_dst_x), 32'(got.out_dst_x));
                    compare_field("out_dst_top", 32'(want.out_dst_top),
                                  32'(got.out_dst_top));
                    compare_field("out_src_x", 32'(want.out_src_x), 32'(got.out_src_x));
                    compare_field("out_src_top", 32'(want.out_src_top),
                                  32'(got.out_src_top));
                end
            end
            case (traffic)
                PROFILE_SLOW_SINK:   idle_pct = 66;
                PROFILE_SLOW_SOURCE: idle_pct = 14;
                default:             idle_pct = 0;
            endcase
            res_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= idle_pct);
        end
    end

    // Ends a run that hangs, for instance when a result never comes back.
    initial
    begin : watchdog
        repeat (WATCHDOG_CYCLES) @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : run_test
        int phase;
        int n;
        bit only;
        int sw;
        int sh;
        int dw;
        int dh;
        int rw;
        int rh;

        // The driver and the monitor set every input of the block while
        // reset is held.
        rst_n = 1'b0;

        // Directed requests. Smallest and largest rectangles first.
        fill_profile = PROFILE_SLOW_SINK;
        queue_blit(0, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0);
        queue_blit(0, 8191, 8191, 8191, 8191, 8191, 8191, 0, 0, 0, 0);
        // A fill with a huge left/top trim leaves one pixel and pushes the
        // source corner far out; the opposite extremes are wholly outside.
        queue_blit(1, 8191, 8191, 8191, 8191, 8191, 8191, -8190, -8190, 16383, 16383);
        queue_blit(0, 8191, 8191, 8191, 8191, 8191, 8191, 16383, 16383, -16384, -16384);
        queue_blit(1, 8191, 8191, 8191, 8191, 8191, 8191, -16384, -16384, -16384, -16384);
        // Empty requests.
        queue_blit(0, 100, 100, 100, 100, 0, 5, 0, 0, 0, 0);
        queue_blit(0, 100, 100, 100, 100, 5, 0, 0, 0, 0, 0);
        // Left trim that eats the whole width, and one that leaves a pixel.
        queue_blit(0, 100, 100, 100, 100, 10, 10, -10, 0, 0, 0);
        queue_blit(0, 100, 100, 100, 100, 10, 10, -9, -9, 0, 0);
        // Corner exactly at the far edge of the destination, and one short.
        queue_blit(0, 100, 100, 100, 100, 10, 10, 100, 0, 0, 0);
        queue_blit(0, 100, 100, 100, 100, 10, 10, 99, 99, 0, 0);
        // Corner at the far edge of the source: outside for a blit, but a
        // fill does not look at the source image at all.
        queue_blit(0, 100, 100, 100, 100, 10, 10, 0, 0, 100, 0);
        queue_blit(1, 100, 100, 100, 100, 10, 10, 0, 0, 100, 0);
        // Source trims shift the destination corner.
        queue_blit(0, 100, 100, 100, 100, 20, 20, 5, 5, -3, -7);
        // The rectangle overruns both images at the right and bottom.
        queue_blit(0, 50, 60, 40, 30, 100, 100, 10, 10, 20, 20);
        // A fill whose source corner is far negative and is only shifted.
        queue_blit(1, 1, 1, 200, 200, 50, 50, -20, -30, -16384, -16384);
        // Images of zero size leave nothing, except the source of a fill.
        queue_blit(0, 0, 100, 100, 100, 5, 5, 0, 0, 0, 0);
        queue_blit(0, 100, 100, 100, 0, 5, 5, 0, 0, 0, 0);
        queue_blit(1, 0, 0, 100, 100, 5, 5, 0, 0, 0, 0);
        // All-ones sizes with corners of minus one.
        queue_blit(0, 8191, 8191, 8191, 8191, 8191, 8191, -1, -1, -1, -1);

        // Random requests, in three traffic phases. Each phase starts by
        // letting the pipeline run dry; the free-running phase also stalls
        // the receiver for a long stretch while the sender keeps offering.
        for (phase = 0; phase < 3; phase++)
        begin
            fill_profile = traffic_t'(phase);
            fill_drain   = 1'b1;
            for (n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                if (fill_profile == PROFILE_FREE && n == 20)
                begin
                    fill_hold = 1'b1;
                end
                only = ($urandom_range(0, 3) == 0);
                sw   = rand_dim();
                sh   = rand_dim();
                dw   = rand_dim();
                dh   = rand_dim();
                rw   = ($urandom_range(0, 39) == 0) ? 0 : rand_dim();
                rh   = ($urandom_range(0, 39) == 0) ? 0 : rand_dim();
                queue_blit(only, sw, sh, dw, dh, rw, rh,
                           rand_corner(rw, dw), rand_corner(rh, dh),
                           rand_corner(rw, sw), rand_corner(rh, sh));
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the last request beat to be taken, then for every result, then
        // keep the clock running to catch any stray result beat.
        while (request_q.size() != 0 || req_ch.valid)
        begin
            @(posedge clk);
        end
        while (clipped_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_LATENCY + 2) @(posedge clk);

        if (failures == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
